[rtl/rti_pkg.sv]
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types, constants and helpers for the ray/triangle intersection block.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int SAT_IN_W      = 72;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [2:0] vec3_t;

  // one triangle word
  typedef struct packed {
    coord_t v2_z;
    coord_t v2_y;
    coord_t v2_x;
    coord_t v1_z;
    coord_t v1_y;
    coord_t v1_x;
    coord_t v0_z;
    coord_t v0_y;
    coord_t v0_x;
  } tri_in_t;

  // one result word
  typedef struct packed {
    logic   hit;
    coord_t hit_x;
    coord_t hit_y;
    coord_t hit_z;
  } hit_out_t;

  // ray held in registers
  typedef struct packed {
    coord_t org_x;
    coord_t org_y;
    coord_t org_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
  } ray_cfg_t;

  // data riding along the divider
  typedef struct packed {
    vec3_t v0;
    vec3_t e1;
    vec3_t e2;
    logic  neg_u;
    logic  neg_v;
    logic  miss;
  } side_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } reg_idx_t;

  // clamp to the signed coordinate range
  function automatic coord_t sat32(input logic signed [SAT_IN_W-1:0] x);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'(64'sh7FFF_FFFF);
    lo = -SAT_IN_W'(64'sh8000_0000);
    if (x > hi) begin
      return coord_t'(hi);
    end else if (x < lo) begin
      return coord_t'(lo);
    end
    return coord_t'(x);
  endfunction

  // tolerance: 0.0001 in fixed point, rounded, at least one LSB
  function automatic int eps_q(input int frac);
    int raw;
    raw = ((1 << frac) + 5000) / 10000;
    return (raw == 0) ? 1 : raw;
  endfunction

endpackage

[rtl/rti_cfg.sv]
// ----------------------------------------------------------------------------
// rti_cfg
// APB register file holding the ray origin and direction.
// ----------------------------------------------------------------------------
module rti_cfg #(
  parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rti_pkg::ADDR_W-1:0]  paddr,
  input  logic [rti_pkg::DATA_W-1:0]  pwdata,
  output logic [rti_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output rti_pkg::ray_cfg_t           ray
);

  rti_pkg::reg_idx_t idx;

  assign idx    = rti_pkg::reg_idx_t'(paddr[rti_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ray.org_x <= '0;
      ray.org_y <= '0;
      ray.org_z <= '0;
      ray.dir_x <= '0;
      ray.dir_y <= '0;
      ray.dir_z <= rti_pkg::coord_t'(1 << FRAC_BITS);
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        rti_pkg::REG_ORIGIN_X: ray.org_x <= pwdata;
        rti_pkg::REG_ORIGIN_Y: ray.org_y <= pwdata;
        rti_pkg::REG_ORIGIN_Z: ray.org_z <= pwdata;
        rti_pkg::REG_DIR_X:    ray.dir_x <= pwdata;
        rti_pkg::REG_DIR_Y:    ray.dir_y <= pwdata;
        rti_pkg::REG_DIR_Z:    ray.dir_z <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      rti_pkg::REG_ORIGIN_X: prdata = ray.org_x;
      rti_pkg::REG_ORIGIN_Y: prdata = ray.org_y;
      rti_pkg::REG_ORIGIN_Z: prdata = ray.org_z;
      rti_pkg::REG_DIR_X:    prdata = ray.dir_x;
      rti_pkg::REG_DIR_Y:    prdata = ray.dir_y;
      rti_pkg::REG_DIR_Z:    prdata = ray.dir_z;
      default:               prdata = '0;
    endcase
  end

endmodule

[rtl/rti_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// rti_pipe_ctrl
// Valid bits and per-stage load enables; bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module rti_pipe_ctrl #(
  parameter int NST = 27
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           tri_valid,
  output logic           tri_ready,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [NST-1:0] en
);

  logic [NST-1:0] vld;
  logic [NST-1:0] vld_in;
  logic [NST:0]   chain;

  // a stage loads when it is empty or its successor loads
  always_comb begin
    chain[NST] = res_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      chain[k] = !vld[k] || chain[k+1];
    end
  end

  // valid bit offered to each stage by its predecessor
  assign vld_in    = {vld[NST-2:0], tri_valid};
  assign en        = chain[NST-1:0];
  assign tri_ready = chain[0];
  assign res_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (chain[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

endmodule

[rtl/rti_geom.sv]
// ----------------------------------------------------------------------------
// rti_geom
// Edges, cross products, dot products and early-out flags (six stages).
// ----------------------------------------------------------------------------
module rti_geom #(
  parameter  int FRAC_BITS = rti_pkg::FRAC_BITS_DEF,
  localparam int DW        = 66 - FRAC_BITS
) (
  input  logic              clk,
  input  logic [5:0]        en,
  input  rti_pkg::ray_cfg_t ray,
  input  rti_pkg::tri_in_t  din,
  output rti_pkg::side_t    side,
  output logic [DW-1:0]     mag_det,
  output logic [DW-1:0]     mag_nu,
  output logic [DW-1:0]     mag_nv
);

  localparam int SW  = rti_pkg::SAT_IN_W;
  localparam int EPS = rti_pkg::eps_q(FRAC_BITS);

  rti_pkg::vec3_t org, dir, vin0, vin1, vin2;

  assign org  = {ray.org_z, ray.org_y, ray.org_x};
  assign dir  = {ray.dir_z, ray.dir_y, ray.dir_x};
  assign vin0 = {din.v0_z, din.v0_y, din.v0_x};
  assign vin1 = {din.v1_z, din.v1_y, din.v1_x};
  assign vin2 = {din.v2_z, din.v2_y, din.v2_x};

  // stage 0: edges and origin offset
  rti_pkg::vec3_t s0_v0, s0_e1, s0_e2, s0_t;
  logic signed [32:0] d_e1 [3];
  logic signed [32:0] d_e2 [3];
  logic signed [32:0] d_t  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_e1[i] = $signed({vin1[i][31], vin1[i]}) - $signed({vin0[i][31], vin0[i]});
      d_e2[i] = $signed({vin2[i][31], vin2[i]}) - $signed({vin0[i][31], vin0[i]});
      d_t[i]  = $signed({org[i][31], org[i]})   - $signed({vin0[i][31], vin0[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_v0 <= vin0;
      for (int i = 0; i < 3; i++) begin
        s0_e1[i] <= rti_pkg::sat32(SW'(d_e1[i]));
        s0_e2[i] <= rti_pkg::sat32(SW'(d_e2[i]));
        s0_t[i]  <= rti_pkg::sat32(SW'(d_t[i]));
      end
    end
  end

  // stage 1: cross product terms, p = dir x e2, q = t x e1
  rti_pkg::vec3_t s1_v0, s1_e1, s1_e2, s1_t;
  logic signed [63:0] s1_pa [3];
  logic signed [63:0] s1_pb [3];
  logic signed [63:0] s1_qa [3];
  logic signed [63:0] s1_qb [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_v0 <= s0_v0;
      s1_e1 <= s0_e1;
      s1_e2 <= s0_e2;
      s1_t  <= s0_t;
      for (int i = 0; i < 3; i++) begin
        s1_pa[i] <= $signed(dir[(i+1)%3]) * $signed(s0_e2[(i+2)%3]);
        s1_pb[i] <= $signed(dir[(i+2)%3]) * $signed(s0_e2[(i+1)%3]);
        s1_qa[i] <= $signed(s0_t[(i+1)%3]) * $signed(s0_e1[(i+2)%3]);
        s1_qb[i] <= $signed(s0_t[(i+2)%3]) * $signed(s0_e1[(i+1)%3]);
      end
    end
  end

  // stage 2: difference, rescale, clamp
  rti_pkg::vec3_t s2_v0, s2_e1, s2_e2, s2_t, s2_p, s2_q;
  logic signed [64:0] dp [3];
  logic signed [64:0] dq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dp[i] = (65'(s1_pa[i]) - 65'(s1_pb[i])) >>> FRAC_BITS;
      dq[i] = (65'(s1_qa[i]) - 65'(s1_qb[i])) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_v0 <= s1_v0;
      s2_e1 <= s1_e1;
      s2_e2 <= s1_e2;
      s2_t  <= s1_t;
      for (int i = 0; i < 3; i++) begin
        s2_p[i] <= rti_pkg::sat32(SW'(dp[i]));
        s2_q[i] <= rti_pkg::sat32(SW'(dq[i]));
      end
    end
  end

  // stage 3: dot product terms
  rti_pkg::vec3_t s3_v0, s3_e1, s3_e2;
  logic signed [63:0] s3_md [3];
  logic signed [63:0] s3_mu [3];
  logic signed [63:0] s3_mv [3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_v0 <= s2_v0;
      s3_e1 <= s2_e1;
      s3_e2 <= s2_e2;
      for (int i = 0; i < 3; i++) begin
        s3_md[i] <= $signed(s2_e1[i]) * $signed(s2_p[i]);
        s3_mu[i] <= $signed(s2_t[i]) * $signed(s2_p[i]);
        s3_mv[i] <= $signed(dir[i]) * $signed(s2_q[i]);
      end
    end
  end

  // stage 4: rescaled sums det, nu, nv
  rti_pkg::vec3_t s4_v0, s4_e1, s4_e2;
  logic signed [DW-1:0] s4_det, s4_nu, s4_nv;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_v0  <= s3_v0;
      s4_e1  <= s3_e1;
      s4_e2  <= s3_e2;
      s4_det <= DW'(s3_md[0] >>> FRAC_BITS) + DW'(s3_md[1] >>> FRAC_BITS)
              + DW'(s3_md[2] >>> FRAC_BITS);
      s4_nu  <= DW'(s3_mu[0] >>> FRAC_BITS) + DW'(s3_mu[1] >>> FRAC_BITS)
              + DW'(s3_mu[2] >>> FRAC_BITS);
      s4_nv  <= DW'(s3_mv[0] >>> FRAC_BITS) + DW'(s3_mv[1] >>> FRAC_BITS)
              + DW'(s3_mv[2] >>> FRAC_BITS);
    end
  end

  // stage 5: magnitudes, signs, early misses
  logic [DW-1:0] a_det, a_nu, a_nv;
  logic [DW:0]   two_det;

  always_comb begin
    a_det   = s4_det[DW-1] ? DW'(-s4_det) : DW'(s4_det);
    a_nu    = s4_nu[DW-1]  ? DW'(-s4_nu)  : DW'(s4_nu);
    a_nv    = s4_nv[DW-1]  ? DW'(-s4_nv)  : DW'(s4_nv);
    two_det = {a_det, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      side.v0    <= s4_v0;
      side.e1    <= s4_e1;
      side.e2    <= s4_e2;
      side.neg_u <= s4_nu[DW-1] ^ s4_det[DW-1];
      side.neg_v <= s4_nv[DW-1] ^ s4_det[DW-1];
      side.miss  <= (a_det < DW'(EPS)) || ({1'b0, a_nu} > two_det)
                 || ({1'b0, a_nv} > two_det);
      mag_det    <= a_det;
      mag_nu     <= a_nu;
      mag_nv     <= a_nv;
    end
  end

endmodule

[rtl/rti_div.sv]
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider, one quotient bit per stage, for u and v
// against a shared divisor |det|.
// ----------------------------------------------------------------------------
module rti_div #(
  parameter  int FRAC_BITS = rti_pkg::FRAC_BITS_DEF,
  localparam int DW        = 66 - FRAC_BITS,
  localparam int QW        = FRAC_BITS + 2
) (
  input  logic           clk,
  input  logic [QW-1:0]  en,
  input  rti_pkg::side_t side_in,
  input  logic [DW-1:0]  a_u,
  input  logic [DW-1:0]  a_v,
  input  logic [DW-1:0]  b_in,
  output rti_pkg::side_t side_out,
  output logic [QW-1:0]  q_u,
  output logic [QW-1:0]  q_v
);

  localparam int RW = DW + 1;

  rti_pkg::side_t sd   [QW];
  logic [RW-1:0]  r_u  [QW];
  logic [RW-1:0]  r_v  [QW];
  logic [QW-1:0]  qq_u [QW];
  logic [QW-1:0]  qq_v [QW];
  logic [DW-1:0]  bb   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    rti_pkg::side_t sd_p;
    logic [RW-1:0]  ru_p, rv_p, ru_i, rv_i, cmp;
    logic [QW-1:0]  qu_p, qv_p;
    logic [DW-1:0]  b_p;
    logic           ge_u, ge_v;

    // previous stage, or the divider inputs
    if (k == 0) begin : g_first
      assign sd_p = side_in;
      assign ru_p = {1'b0, a_u};
      assign rv_p = {1'b0, a_v};
      assign qu_p = '0;
      assign qv_p = '0;
      assign b_p  = b_in;
    end else begin : g_next
      assign sd_p = sd[k-1];
      assign ru_p = r_u[k-1];
      assign rv_p = r_v[k-1];
      assign qu_p = qq_u[k-1];
      assign qv_p = qq_v[k-1];
      assign b_p  = bb[k-1];
    end

    // first two steps settle the integer part (2 then 1); the rest shift
    always_comb begin
      if (k == 0) begin
        cmp  = {b_p, 1'b0};
        ru_i = ru_p;
        rv_i = rv_p;
      end else if (k == 1) begin
        cmp  = {1'b0, b_p};
        ru_i = ru_p;
        rv_i = rv_p;
      end else begin
        cmp  = {1'b0, b_p};
        ru_i = {ru_p[RW-2:0], 1'b0};
        rv_i = {rv_p[RW-2:0], 1'b0};
      end
      ge_u = ru_i >= cmp;
      ge_v = rv_i >= cmp;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        sd[k]   <= sd_p;
        bb[k]   <= b_p;
        r_u[k]  <= ge_u ? ru_i - cmp : ru_i;
        r_v[k]  <= ge_v ? rv_i - cmp : rv_i;
        qq_u[k] <= {qu_p[QW-2:0], ge_u};
        qq_v[k] <= {qv_p[QW-2:0], ge_v};
      end
    end
  end

  assign side_out = sd[QW-1];
  assign q_u      = qq_u[QW-1];
  assign q_v      = qq_v[QW-1];

endmodule

[rtl/rti_point.sv]
// ----------------------------------------------------------------------------
// rti_point
// Barycentric range checks and hit point v0 + u*e1 + v*e2 (three stages,
// the last one is the output register).
// ----------------------------------------------------------------------------
module rti_point #(
  parameter  int FRAC_BITS = rti_pkg::FRAC_BITS_DEF,
  localparam int QW        = FRAC_BITS + 2
) (
  input  logic               clk,
  input  logic [2:0]         en,
  input  rti_pkg::side_t     side_in,
  input  logic [QW-1:0]      q_u,
  input  logic [QW-1:0]      q_v,
  output rti_pkg::hit_out_t  dout
);

  localparam int SW  = rti_pkg::SAT_IN_W;
  localparam int UW  = QW + 2;
  localparam int PW  = rti_pkg::COORD_W + QW + 1;
  localparam int EPS = rti_pkg::eps_q(FRAC_BITS);
  localparam int HI  = (1 << FRAC_BITS) + EPS;

  // stage 0: signed u, v and the range test
  logic signed [UW-1:0] u_w, v_w, s_w;
  logic                 miss;

  always_comb begin
    u_w  = UW'($signed({1'b0, q_u}));
    v_w  = UW'($signed({1'b0, q_v}));
    if (side_in.neg_u) u_w = -u_w;
    if (side_in.neg_v) v_w = -v_w;
    s_w  = u_w + v_w;
    miss = side_in.miss || (u_w < UW'(-EPS)) || (u_w > UW'(HI))
        || (v_w < UW'(-EPS)) || (s_w > UW'(HI));
  end

  rti_pkg::vec3_t     s0_v0, s0_e1, s0_e2;
  logic signed [QW:0] s0_u, s0_v;
  logic               s0_miss;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_v0   <= side_in.v0;
      s0_e1   <= side_in.e1;
      s0_e2   <= side_in.e2;
      s0_u    <= (QW+1)'(u_w);
      s0_v    <= (QW+1)'(v_w);
      s0_miss <= miss;
    end
  end

  // stage 1: edge scaling products
  rti_pkg::vec3_t       s1_v0;
  logic signed [PW-1:0] s1_mu [3];
  logic signed [PW-1:0] s1_mv [3];
  logic                 s1_miss;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_v0   <= s0_v0;
      s1_miss <= s0_miss;
      for (int i = 0; i < 3; i++) begin
        s1_mu[i] <= $signed(s0_e1[i]) * s0_u;
        s1_mv[i] <= $signed(s0_e2[i]) * s0_v;
      end
    end
  end

  // stage 2: sum, clamp, zero on a miss
  rti_pkg::vec3_t         pt;
  logic signed [SW-1:0]   acc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = SW'($signed(s1_v0[i])) + SW'(s1_mu[i] >>> FRAC_BITS)
             + SW'(s1_mv[i] >>> FRAC_BITS);
      pt[i]  = s1_miss ? '0 : rti_pkg::sat32(acc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dout.hit   <= !s1_miss;
      dout.hit_x <= pt[0];
      dout.hit_y <= pt[1];
      dout.hit_z <= pt[2];
    end
  end

endmodule

[rtl/ray_triangle_intersect_top.sv]
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// Moller-Trumbore ray/triangle test in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   The ray (origin, direction) is written over the APB port; registers sit
//   at byte addresses 0x00..0x14 (origin x/y/z, direction x/y/z). Write them
//   only while the pipeline is empty.
//   Each word on the tri channel (tri_valid/tri_ready/tri_data) carries the
//   three vertices of one triangle. Each accepted word yields exactly one
//   word on the res channel (res_valid/res_ready/res_data): hit flag and the
//   hit point, zero on a miss.
//   Pipeline: six geometry stages, FRAC_BITS + 2 divider stages (one
//   quotient bit each) and three point stages, the last being the output
//   register; FRAC_BITS defaults to 16 (Q16.16).
//   Throughput: one triangle per cycle while tri_ready is high. When
//   res_ready is low the result holds; empty stages keep filling, so
//   tri_ready drops only once every stage holds a word.
//   Reset: the pipeline empties, origin goes to 0, direction to +z (1.0).
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top #(
  parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       tri_valid,
  output logic                       tri_ready,
  input  rti_pkg::tri_in_t           tri_data,
  output logic                       res_valid,
  input  logic                       res_ready,
  output rti_pkg::hit_out_t          res_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rti_pkg::ADDR_W-1:0] paddr,
  input  logic [rti_pkg::DATA_W-1:0] pwdata,
  output logic [rti_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int DW  = 66 - FRAC_BITS;
  localparam int QW  = FRAC_BITS + 2;
  localparam int NG  = 6;
  localparam int NP  = 3;
  localparam int NST = NG + QW + NP;

  rti_pkg::ray_cfg_t ray;
  rti_pkg::side_t    g_side, d_side;
  logic [NST-1:0]    en;
  logic [DW-1:0]     mag_det, mag_nu, mag_nv;
  logic [QW-1:0]     q_u, q_v;

  rti_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ray     (ray)
  );

  rti_pipe_ctrl #(.NST(NST)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tri_valid (tri_valid),
    .tri_ready (tri_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .en        (en)
  );

  rti_geom #(.FRAC_BITS(FRAC_BITS)) u_geom (
    .clk     (clk),
    .en      (en[NG-1:0]),
    .ray     (ray),
    .din     (tri_data),
    .side    (g_side),
    .mag_det (mag_det),
    .mag_nu  (mag_nu),
    .mag_nv  (mag_nv)
  );

  rti_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .en       (en[NG+QW-1:NG]),
    .side_in  (g_side),
    .a_u      (mag_nu),
    .a_v      (mag_nv),
    .b_in     (mag_det),
    .side_out (d_side),
    .q_u      (q_u),
    .q_v      (q_v)
  );

  rti_point #(.FRAC_BITS(FRAC_BITS)) u_point (
    .clk     (clk),
    .en      (en[NST-1:NG+QW]),
    .side_in (d_side),
    .q_u     (q_u),
    .q_v     (q_v),
    .dout    (res_data)
  );

endmodule
